[hdl/met_pkg.sv]
// shared constants and the token type for the escape-time iteration chain
// no dependencies; used by met_cell and mandelbrot_escape_time_unit
package met_pkg;

    localparam int MAX_ITER = 30;
    localparam int N_CELLS  = MAX_ITER + 1;
    localparam int CNT_W    = $clog2(MAX_ITER + 2);

    localparam int C_W      = 32;  // c_real / c_imag, Q4.28
    localparam int ESC_W    = 5;   // escape_count port width
    localparam int FRAC_W   = 28;

    // z inside the bound (|x|,|y| <= 2) fits 31 signed bits
    localparam int Z_W      = 31;
    // updated z before the bound check: |x| <= 12, |y| <= 16
    localparam int ZN_W     = 34;
    localparam int PROD_W   = 2 * Z_W;
    localparam int DIFF_W   = PROD_W + 1;

    localparam logic signed [ZN_W-1:0]   TWO_Q28  = ZN_W'(2 ** (FRAC_W + 1));
    localparam logic signed [ZN_W-1:0]   MTWO_Q28 = -TWO_Q28;
    localparam logic [PROD_W-1:0]        FOUR_Q56 = PROD_W'(1) << (2 * FRAC_W + 2);

    typedef struct packed {
        logic                    done;
        logic [CNT_W-1:0]        count;
        logic signed [Z_W-1:0]   x;
        logic signed [Z_W-1:0]   y;
        logic signed [C_W-1:0]   cr;
        logic signed [C_W-1:0]   ci;
    } met_token_t;

endpackage

[hdl/mandelbrot_escape_time_unit.sv]
// top level of the escape-time iteration chain: a row of met_cell instances
// and the output word register; depends on met_pkg and met_cell
//
// Each point c (Q4.28) walks down a chain of MAX_ITER+1 identical cells, one
// iteration z = z*z + c per cell; a cell registers the three products in its
// first stage and the magnitude test and the update in its second, and the
// output word register follows the last cell. One point is accepted every
// cycle while the output is not stalled. escape_count is the first step
// after which |z|^2 > 4, or MAX_ITER+1 if that never happened; dividing by
// MAX_ITER is up to the consumer. When the result word is not taken the
// whole chain holds, so s_ready follows m_ready while the output is full.
module mandelbrot_escape_time_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [met_pkg::C_W-1:0] s_c_real,
    input  logic signed [met_pkg::C_W-1:0] s_c_imag,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [met_pkg::ESC_W-1:0]    m_escape_count
);

    logic                    en;
    logic                    chain_valid [met_pkg::N_CELLS+1];
    met_pkg::met_token_t     chain_tok   [met_pkg::N_CELLS+1];

    logic                         m_valid_reg;
    logic [met_pkg::ESC_W-1:0]    m_escape_count_reg;

    // whole chain advances unless a result word is stuck at the output
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        chain_valid[0]       = s_valid;
        chain_tok[0].done    = 1'b0;
        chain_tok[0].count   = '0;
        chain_tok[0].x       = '0;
        chain_tok[0].y       = '0;
        chain_tok[0].cr      = s_c_real;
        chain_tok[0].ci      = s_c_imag;
    end

    for (genvar i = 0; i < met_pkg::N_CELLS; i++) begin : g_cell
        met_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_tok    (chain_tok[i]),
            .out_valid (chain_valid[i+1]),
            .out_tok   (chain_tok[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= chain_valid[met_pkg::N_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_escape_count_reg <= met_pkg::ESC_W'(chain_tok[met_pkg::N_CELLS].count);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_escape_count = m_escape_count_reg;

    // counts run 1..MAX_ITER+1, so zero shows up only once the 5-bit field wraps
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_escape_count_reg != '0 || met_pkg::MAX_ITER >= 31))
        else $error("zero escape count");

    // the last cell always hands over a token with its step count filled in
    assert property (@(posedge aclk) disable iff (!aresetn)
        chain_valid[met_pkg::N_CELLS] |->
            chain_tok[met_pkg::N_CELLS].count != '0)
        else $error("token left the chain without a step count");

    // a stalled output freezes the chain tail too
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(chain_valid[met_pkg::N_CELLS]))
        else $error("chain moved during stall");

endmodule

[hdl/met_cell.sv]
// one iteration cell: squares z in the first stage, tests the magnitude and
// forms z*z + c in the second; depends on met_pkg
module met_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  met_pkg::met_token_t in_tok,
    output logic                out_valid,
    output met_pkg::met_token_t out_tok
);

    logic                                 a_valid_reg;
    met_pkg::met_token_t                  a_tok_reg;
    logic signed [met_pkg::PROD_W-1:0]    pxx_reg, pyy_reg, pxy_reg;
    logic signed [met_pkg::PROD_W-1:0]    pxx_next, pyy_next, pxy_next;

    logic                                 b_valid_reg;
    met_pkg::met_token_t                  b_tok_reg;
    met_pkg::met_token_t                  b_tok_next;

    logic signed [met_pkg::DIFF_W-1:0]    diff;
    logic signed [met_pkg::DIFF_W-1:0]    diff_sh;
    logic signed [met_pkg::PROD_W-1:0]    xy2_sh;
    logic signed [met_pkg::ZN_W-1:0]      nx, ny;
    logic [met_pkg::PROD_W-1:0]           mag2;
    logic                                 esc, big;

    // stage a: the three products
    assign pxx_next = met_pkg::PROD_W'(in_tok.x) * met_pkg::PROD_W'(in_tok.x);
    assign pyy_next = met_pkg::PROD_W'(in_tok.y) * met_pkg::PROD_W'(in_tok.y);
    assign pxy_next = met_pkg::PROD_W'(in_tok.x) * met_pkg::PROD_W'(in_tok.y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_tok_reg <= in_tok;
            pxx_reg   <= pxx_next;
            pyy_reg   <= pyy_next;
            pxy_reg   <= pxy_next;
        end
    end

    // stage b: escape test on the incoming z, then the next z
    always_comb begin
        mag2    = met_pkg::PROD_W'(pxx_reg) + met_pkg::PROD_W'(pyy_reg);
        esc     = mag2 > met_pkg::FOUR_Q56;
        diff    = met_pkg::DIFF_W'(pxx_reg) - met_pkg::DIFF_W'(pyy_reg);
        diff_sh = diff >>> met_pkg::FRAC_W;
        // 2*x*y rescaled is x*y shifted one less
        xy2_sh  = pxy_reg >>> (met_pkg::FRAC_W - 1);
        nx      = met_pkg::ZN_W'(diff_sh) + met_pkg::ZN_W'(a_tok_reg.cr);
        ny      = met_pkg::ZN_W'(xy2_sh) + met_pkg::ZN_W'(a_tok_reg.ci);
        big     = (nx > met_pkg::TWO_Q28) || (nx < met_pkg::MTWO_Q28) ||
                  (ny > met_pkg::TWO_Q28) || (ny < met_pkg::MTWO_Q28);

        b_tok_next = a_tok_reg;
        if (!a_tok_reg.done) begin
            if (esc) begin
                // escaped at the previous step, count already holds it
                b_tok_next.done = 1'b1;
            end else begin
                b_tok_next.count = a_tok_reg.count + met_pkg::CNT_W'(1);
                b_tok_next.x     = met_pkg::Z_W'(nx);
                b_tok_next.y     = met_pkg::Z_W'(ny);
                b_tok_next.done  = big;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_tok_reg <= b_tok_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_tok   = b_tok_reg;

    // a finished point passes through unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        en && a_valid_reg && a_tok_reg.done |=>
            b_tok_reg.done && b_tok_reg.count == $past(a_tok_reg.count))
        else $error("finished point modified in cell");

    // each cell advances the step count by at most one
    assert property (@(posedge aclk) disable iff (!aresetn)
        en && a_valid_reg |=>
            b_tok_reg.count == $past(a_tok_reg.count) ||
            b_tok_reg.count == $past(a_tok_reg.count) + met_pkg::CNT_W'(1))
        else $error("step count jumped");

    // a live point leaving the cell is inside the bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_tok_reg.done |->
            met_pkg::ZN_W'(b_tok_reg.x) <= met_pkg::TWO_Q28 &&
            met_pkg::ZN_W'(b_tok_reg.x) >= met_pkg::MTWO_Q28 &&
            met_pkg::ZN_W'(b_tok_reg.y) <= met_pkg::TWO_Q28 &&
            met_pkg::ZN_W'(b_tok_reg.y) >= met_pkg::MTWO_Q28)
        else $error("live point outside bound");

endmodule

[bench/mandelbrot_escape_time_unit_tb.sv]
// self-checking bench for mandelbrot_escape_time_unit: escape-step prediction per point,
// random source gaps and sink stalls; depends on met_pkg and the escape-time chain rtl
`timescale 1ns / 100ps

module mandelbrot_escape_time_unit_tb;

    localparam int     RANDOM_POINTS = 1800;
    localparam int     MAX_WAIT      = 18;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     DRAIN_CYCLES  = 2 * (met_pkg::MAX_ITER + 1) + 20;
    localparam longint Z_BOUND       = longint'(1) << (met_pkg::FRAC_W + 1);
    localparam longint FOUR_SQ       = longint'(1) << (2 * met_pkg::FRAC_W + 2);
    localparam longint ONE_Q         = longint'(1) << met_pkg::FRAC_W;

    typedef struct {
        logic signed [met_pkg::C_W-1:0] cr;
        logic signed [met_pkg::C_W-1:0] ci;
    } point_t;

    typedef struct {
        point_t                      pt;
        logic [met_pkg::ESC_W-1:0]   steps;
    } escape_word_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic signed [met_pkg::C_W-1:0] s_c_real;
    logic signed [met_pkg::C_W-1:0] s_c_imag;
    logic                           m_valid;
    logic                           m_ready;
    logic [met_pkg::ESC_W-1:0]      m_escape_count;

    point_t       point_q[$];
    escape_word_t escape_q[$];
    int           points_total;
    int           points_sent = 0;
    int           errors      = 0;
    int           cycles      = 0;
    int           send_gap;
    int           take_gap;
    bit           calm        = 1'b0;

    mandelbrot_escape_time_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_c_real       (s_c_real),
        .s_c_imag       (s_c_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // first step after which |z|^2 > 4, or MAX_ITER+1 when z stays bounded
    function automatic logic [met_pkg::ESC_W-1:0] escape_steps(
            input logic signed [met_pkg::C_W-1:0] cr,
            input logic signed [met_pkg::C_W-1:0] ci);
        longint x, y, xx, yy, xy2, ax, ay;
        int     steps;
        x     = 0;
        y     = 0;
        steps = met_pkg::MAX_ITER + 1;
        for (int n = 1; n <= met_pkg::MAX_ITER; n++) begin
            xx  = x * x;
            yy  = y * y;
            xy2 = 2 * x * y;
            x   = ((xx - yy) >>> met_pkg::FRAC_W) + longint'(cr);
            y   = (xy2 >>> met_pkg::FRAC_W) + longint'(ci);
            ax  = (x < 0) ? -x : x;
            ay  = (y < 0) ? -y : y;
            // the bound test keeps the squares from overflowing
            if (ax > Z_BOUND || ay > Z_BOUND || ax * ax + ay * ay > FOUR_SQ) begin
                steps = n;
                break;
            end
        end
        return met_pkg::ESC_W'(steps);
    endfunction

    function automatic int draw_wait();
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("%0t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic add_point(input longint cr, input longint ci);
        point_t p;
        p.cr = met_pkg::C_W'(cr);
        p.ci = met_pkg::C_W'(ci);
        point_q.push_back(p);
        points_total++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        calm   <= ((cycles / 1500) % 4) == 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("mandelbrot_escape_time_unit_tb failed");
            $finish;
        end
    end

    // source side: one word per handshake, gaps between words drawn per word
    always @(posedge aclk) begin : source
        point_t       p;
        escape_word_t w;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_c_real <= '0;
            s_c_imag <= '0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                w.pt.cr = s_c_real;
                w.pt.ci = s_c_imag;
                w.steps = escape_steps(s_c_real, s_c_imag);
                escape_q.push_back(w);
                points_sent++;
            end
            if (send_gap != 0 || point_q.size() == 0) begin
                s_valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end else begin
                p = point_q.pop_front();
                s_c_real <= p.cr;
                s_c_imag <= p.ci;
                s_valid  <= 1'b1;
                send_gap <= draw_wait();
            end
        end
    end

    // sink side: stalls drawn per word taken
    always @(posedge aclk) begin : sink
        escape_word_t w;
        int           hold;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            take_gap <= 0;
        end else begin
            hold = take_gap;
            if (m_valid && m_ready) begin
                if (escape_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, escape_count %0d",
                                              m_escape_count));
                end else begin
                    w = escape_q.pop_front();
                    if (m_escape_count !== w.steps)
                        report_mismatch($sformatf(
                            "c = (%h, %h): escape_count %0d, predicted %0d",
                            w.pt.cr, w.pt.ci, m_escape_count, w.steps));
                end
                hold = draw_wait();
            end else if (hold > 0) begin
                hold = hold - 1;
            end
            take_gap <= hold;
            m_ready  <= (hold == 0);
        end
    end

    initial begin
        longint base_r[6];
        longint base_i[6];
        int     k;
        int     pick;
        aresetn      = 1'b0;
        points_total = 0;

        // directed: origin, the exact threshold, just past it, field extremes, cycles
        add_point(0, 0);
        add_point(-2 * ONE_Q, 0);            // lands on x = 2 forever, never escapes
        add_point(2 * ONE_Q, 0);             // |z|^2 == 4 after step 1, escapes on step 2
        add_point(0, 2 * ONE_Q);
        add_point(0, -2 * ONE_Q);
        add_point(2 * ONE_Q + 1, 0);         // just past the bound: escapes on step 1
        add_point(-2 * ONE_Q - 1, 0);
        add_point(0, 2 * ONE_Q + 1);
        add_point(0, -2 * ONE_Q - 1);
        add_point(32'sh7fffffff, 32'sh7fffffff);
        add_point(-32'sh80000000, -32'sh80000000);
        add_point(32'sh7fffffff, -32'sh80000000);
        add_point(-32'sh80000000, 32'sh7fffffff);
        add_point(-ONE_Q, 0);
        add_point(0, ONE_Q);
        add_point(0, -ONE_Q);
        add_point(ONE_Q / 4, 0);
        add_point(ONE_Q / 4 + ONE_Q / 100, 0);
        add_point(-(ONE_Q * 3) / 4, ONE_Q / 10);
        add_point(-ONE_Q / 10, (ONE_Q * 651) / 1000);
        add_point(ONE_Q, ONE_Q);
        add_point(-1, -1);

        // spots near the set boundary, where counts spread over the whole range
        base_r = '{ONE_Q / 4, -(ONE_Q * 3) / 4, -2 * ONE_Q, -ONE_Q / 10,
                   -(ONE_Q * 5) / 4, ONE_Q / 3};
        base_i = '{0, ONE_Q / 10, 0, (ONE_Q * 651) / 1000, 0, ONE_Q / 2};

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                add_point(longint'($urandom_range(0, 3 * ONE_Q)) - (ONE_Q * 9) / 4,
                          longint'($urandom_range(0, 3 * ONE_Q)) - (ONE_Q * 3) / 2);
            end else if (pick < 16) begin
                k = $urandom_range(0, 5);
                add_point(base_r[k] + longint'($urandom_range(0, 1 << 21)) - (1 << 20),
                          base_i[k] + longint'($urandom_range(0, 1 << 21)) - (1 << 20));
            end else begin
                add_point(longint'($signed($urandom())), longint'($signed($urandom())));
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        wait (points_sent == points_total);
        while (escape_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("mandelbrot_escape_time_unit_tb passed");
        end else begin
            $display("mandelbrot_escape_time_unit_tb failed");
        end
        $finish;
    end

endmodule
